// File: design/ape_pkg.sv
// ---------------------------------------------------------------------------
// ape_pkg: shared types and constants of the aberration phase evaluator
// Payload structs, controller states, datapath operation codes and the
// fixed-point constants of the sine/cosine series.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ape_pkg;

   localparam int MAX_TERMS = 16;
   localparam int MAX_ORDER = 8;
   localparam int IDX_W = $clog2(MAX_TERMS);
   localparam int K_W = $clog2(MAX_TERMS + 1);

   // Register indexes of the configuration port.
   localparam logic REG_WAVELENGTH = 1'b0;
   localparam logic REG_TERM_COUNT = 1'b1;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [32:0] ONE_Q30 = 33'd1 << 30;
   localparam logic [63:0] ONE_Q52 = 64'd1 << 52;

   // Six sine steps followed by seven cosine steps share one counter.
   localparam int SIN_STEPS = 6;
   localparam int TRIG_STEPS = 13;

   // Series divisors and their reciprocals floor(2^40 / k); the last three
   // slots are never addressed.
   localparam logic [7:0] DIV_K [16] = '{
      8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
      8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2,
      8'd2, 8'd2, 8'd2};
   localparam logic [39:0] DIV_RECIP [16] = '{
      40'((41'd1 << 40) / 41'd156), 40'((41'd1 << 40) / 41'd110),
      40'((41'd1 << 40) / 41'd72),  40'((41'd1 << 40) / 41'd42),
      40'((41'd1 << 40) / 41'd20),  40'((41'd1 << 40) / 41'd6),
      40'((41'd1 << 40) / 41'd182), 40'((41'd1 << 40) / 41'd132),
      40'((41'd1 << 40) / 41'd90),  40'((41'd1 << 40) / 41'd56),
      40'((41'd1 << 40) / 41'd30),  40'((41'd1 << 40) / 41'd12),
      40'((41'd1 << 40) / 41'd2),   40'((41'd1 << 40) / 41'd2),
      40'((41'd1 << 40) / 41'd2),   40'((41'd1 << 40) / 41'd2)};

   typedef struct packed {
      logic               action;
      logic [3:0]         term_index;
      logic [3:0]         term_m;
      logic [3:0]         term_n;
      logic signed [47:0] term_mag;
      logic [15:0]        term_angle;
      logic [31:0]        spatial_freq;
      logic [15:0]        freq_angle;
   } req_type;

   typedef struct packed {
      logic signed [47:0] phase_shift;
      logic               saturated;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_L_ANG, OP_TX, OP_TX2, OP_TH1, OP_TH2, OP_TH3, OP_TS,
      OP_L_CX, OP_L_SY, OP_P_U, OP_PW_INIT, OP_PW, OP_T_C, OP_T_S,
      OP_INNER, OP_TERM, OP_ACC
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_L_ANG, ST_TX, ST_TX2, ST_TH1, ST_TH2, ST_TH3, ST_TS,
      ST_L_CX, ST_L_SY, ST_P_U, ST_K_CHK, ST_PW_INIT, ST_PW, ST_T_C,
      ST_T_S, ST_INNER, ST_TERM, ST_ACC, ST_DONE
   } state_type;

   typedef struct packed {
      logic   go;
      op_type op;
      logic   capture;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic h_last;
      logic pw_more;
      logic k_more;
   } stat_type;

   function automatic logic is_mul(input op_type op);
      case (op)
         OP_TX, OP_TX2, OP_TH1, OP_TH2, OP_TS, OP_L_CX, OP_L_SY, OP_P_U,
         OP_PW, OP_T_C, OP_T_S, OP_TERM: is_mul = 1'b1;
         default: is_mul = 1'b0;
      endcase
   endfunction

endpackage

// File: design/ape_mul64.sv
// ---------------------------------------------------------------------------
// ape_mul64: multi-cycle 64 x 64 unsigned multiplier
// One 32 x 32 multiplier forms four partial products that are summed into a
// 128-bit accumulator; the product is ready when done is raised.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ape_mul64 (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] prod,
   output logic         done
);

   logic [63:0]  a_ff, b_ff, pp_ff;
   logic [127:0] acc_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic [31:0]  a_half, b_half;
   logic [127:0] pp_sh;

   // Step order: low*low, low*high, high*low, high*high.
   assign a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      case (step_ff)
         3'd1: pp_sh = {64'd0, pp_ff};
         3'd2, 3'd3: pp_sh = {32'd0, pp_ff, 32'd0};
         3'd4: pp_sh = {pp_ff, 64'd0};
         default: pp_sh = 128'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= 3'd0;
      end else if (busy_ff) begin
         if (step_ff == 3'd5) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
         acc_ff <= 128'd0;
      end else if (busy_ff) begin
         if (step_ff < 3'd4) begin
            pp_ff <= a_half * b_half;
         end
         acc_ff <= acc_ff + pp_sh;
      end
   end

   assign prod = acc_ff;
   assign done = busy_ff && (step_ff == 3'd5);

endmodule

// File: design/ape_datapath.sv
// ---------------------------------------------------------------------------
// ape_datapath: term table, trig series and accumulation datapath
// Executes one operation per command from the controller, sharing a single
// multi-cycle multiplier for all 64 x 64 products.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ape_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ape_pkg::cmd_type    cmd,
   input  ape_pkg::req_type    req_data,
   input  logic [31:0]         wavelength,
   input  logic [4:0]          term_count,
   output ape_pkg::stat_type   status,
   output logic signed [47:0]  phase_shift,
   output logic                saturated
);

   // Captured item.
   logic [3:0]         idx_ff, m_ff, n_ff;
   logic signed [47:0] mag_ff;
   logic [15:0]        ang_ff, th_ff;
   logic [31:0]        q_ff;

   // Term table.
   logic [3:0]         m_tab [ape_pkg::MAX_TERMS];
   logic [3:0]         n_tab [ape_pkg::MAX_TERMS];
   logic signed [47:0] cx_tab [ape_pkg::MAX_TERMS];
   logic signed [47:0] sy_tab [ape_pkg::MAX_TERMS];

   // Trig series.
   logic [15:0]        tang_ff;
   logic [30:0]        x_ff, t_ff, ts_ff;
   logic [31:0]        x2_ff, pq_ff, qh_ff;
   logic [3:0]         hidx_ff;
   logic signed [32:0] sn_ff, cs_ff;

   // Pixel evaluation.
   logic [63:0]        u_ff, pw_ff;
   logic [3:0]         j_ff;
   logic [ape_pkg::K_W-1:0] k_ff;
   logic signed [47:0] a_ff, b_ff, inner_ff, term_ff, sum_ff;
   logic               sat_ff, neg_ff;

   ape_pkg::op_type    op_ff;
   logic               active_ff;

   logic [63:0]  mul_a, mul_b;
   logic         neg_in, mul_start, mul_done, done;
   logic [127:0] prod, rnd30, rnd52;
   logic         ovf30, ovf52;
   logic [63:0]  res30, res52;
   logic [48:0]  cl30, cl52, inner_sum, acc_sum;
   logic [ape_pkg::IDX_W-1:0] ki, wi;
   logic         we;
   logic [7:0]   div_k;
   logic [39:0]  qk, rem;
   logic [32:0]  sub, c_val, s_val;
   logic [30:0]  new_t;
   logic [3:0]   m_sat, n_sat;
   logic [ape_pkg::K_W-1:0] cnt, cnt_raw;
   logic signed [32:0] sn_in, cs_in;

   function automatic logic [47:0] abs48(input logic signed [47:0] v);
      abs48 = v[47] ? 48'(-v) : 48'(v);
   endfunction

   function automatic logic [32:0] abs33(input logic signed [32:0] v);
      abs33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   // Clamp a rounded magnitude and apply the sign; top bit flags clipping.
   function automatic logic [48:0] clamp_mag(input logic [63:0] r, input logic neg,
                                             input logic ovf);
      logic [63:0] lim;
      logic [63:0] v;
      logic        s;
      lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
      v = r;
      s = 1'b0;
      if (ovf || (r > lim)) begin
         v = lim;
         s = 1'b1;
      end
      if (neg) begin
         v = -v;
      end
      clamp_mag = {s, v[47:0]};
   endfunction

   function automatic logic [48:0] sadd(input logic signed [47:0] a,
                                        input logic signed [47:0] b);
      logic signed [48:0] s;
      logic               f;
      s = 49'(a) + 49'(b);
      f = 1'b0;
      if (s > 49'sd140737488355327) begin
         s = 49'sd140737488355327;
         f = 1'b1;
      end
      if (s < -49'sd140737488355328) begin
         s = -49'sd140737488355328;
         f = 1'b1;
      end
      sadd = {f, s[47:0]};
   endfunction

   assign ki = k_ff[ape_pkg::IDX_W-1:0];
   assign wi = ape_pkg::IDX_W'(idx_ff);
   assign we = 32'(idx_ff) < 32'(ape_pkg::MAX_TERMS);
   assign m_sat = (32'(req_data.term_m) > 32'(ape_pkg::MAX_ORDER)) ?
                  4'(ape_pkg::MAX_ORDER) : req_data.term_m;
   assign n_sat = (32'(req_data.term_n) > 32'(ape_pkg::MAX_ORDER)) ?
                  4'(ape_pkg::MAX_ORDER) : req_data.term_n;
   assign cnt_raw = ape_pkg::K_W'(term_count);
   assign cnt = (cnt_raw > ape_pkg::K_W'(ape_pkg::MAX_TERMS)) ?
                ape_pkg::K_W'(ape_pkg::MAX_TERMS) : cnt_raw;

   // Operand selection for the multiplier, taken when the command is issued.
   always_comb begin
      mul_a = 64'd0;
      mul_b = 64'd0;
      neg_in = 1'b0;
      case (cmd.op)
         ape_pkg::OP_TX: begin
            mul_a = 64'(tang_ff[13:0]);
            mul_b = 64'(ape_pkg::HALF_PI_Q30);
         end
         ape_pkg::OP_TX2: begin
            mul_a = 64'(x_ff);
            mul_b = 64'(x_ff);
         end
         ape_pkg::OP_TH1: begin
            mul_a = 64'(x2_ff);
            mul_b = 64'(t_ff);
         end
         ape_pkg::OP_TH2: begin
            mul_a = 64'(pq_ff);
            mul_b = 64'(ape_pkg::DIV_RECIP[hidx_ff]);
         end
         ape_pkg::OP_TS: begin
            mul_a = 64'(x_ff);
            mul_b = 64'(ts_ff);
         end
         ape_pkg::OP_L_CX: begin
            mul_a = 64'(abs48(mag_ff));
            mul_b = 64'(abs33(cs_ff));
            neg_in = mag_ff[47] ^ cs_ff[32];
         end
         ape_pkg::OP_L_SY: begin
            mul_a = 64'(abs48(mag_ff));
            mul_b = 64'(abs33(sn_ff));
            neg_in = mag_ff[47] ^ sn_ff[32];
         end
         ape_pkg::OP_P_U: begin
            mul_a = 64'(wavelength);
            mul_b = 64'(q_ff);
         end
         ape_pkg::OP_PW: begin
            mul_a = pw_ff;
            mul_b = u_ff;
         end
         ape_pkg::OP_T_C: begin
            mul_a = 64'(abs48(cx_tab[ki]));
            mul_b = 64'(abs33(cs_ff));
            neg_in = cx_tab[ki][47] ^ cs_ff[32];
         end
         ape_pkg::OP_T_S: begin
            mul_a = 64'(abs48(sy_tab[ki]));
            mul_b = 64'(abs33(sn_ff));
            neg_in = sy_tab[ki][47] ^ sn_ff[32];
         end
         ape_pkg::OP_TERM: begin
            mul_a = 64'(abs48(inner_ff));
            mul_b = pw_ff;
            neg_in = inner_ff[47];
         end
         default: begin
            mul_a = 64'd0;
         end
      endcase
   end

   assign mul_start = cmd.go && ape_pkg::is_mul(cmd.op);

   ape_mul64 u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod),
      .done  (mul_done)
   );

   // Round to nearest on the magnitude, then check for bits beyond 64.
   assign rnd30 = prod + (128'd1 << 29);
   assign rnd52 = prod + (128'd1 << 51);
   assign ovf30 = |rnd30[127:94];
   assign ovf52 = |rnd52[127:116];
   assign res30 = rnd30[93:30];
   assign res52 = rnd52[115:52];
   assign cl30 = clamp_mag(res30, neg_ff, ovf30);
   assign cl52 = clamp_mag(res52, neg_ff, ovf52);
   assign inner_sum = sadd(a_ff, b_ff);
   assign acc_sum = sadd(sum_ff, term_ff);

   // Reciprocal quotient is exact or one short; one compare corrects it.
   assign div_k = ape_pkg::DIV_K[hidx_ff];
   assign qk = 40'(qh_ff) * 40'(div_k);
   assign rem = 40'(pq_ff) - qk;
   assign sub = 33'(qh_ff) + 33'(rem >= 40'(div_k));
   assign new_t = (sub > ape_pkg::ONE_Q30) ? 31'd0 : 31'(ape_pkg::ONE_Q30 - sub);

   // Quadrant mapping of the first-quadrant sine and cosine.
   assign s_val = 33'(prod[60:30]);
   assign c_val = 33'(t_ff);
   always_comb begin
      case (tang_ff[15:14])
         2'd0: begin
            sn_in = s_val;
            cs_in = c_val;
         end
         2'd1: begin
            sn_in = c_val;
            cs_in = -s_val;
         end
         2'd2: begin
            sn_in = -s_val;
            cs_in = -c_val;
         end
         default: begin
            sn_in = -c_val;
            cs_in = s_val;
         end
      endcase
   end

   assign done = active_ff && (ape_pkg::is_mul(op_ff) ? mul_done : 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         op_ff <= ape_pkg::OP_NONE;
         hidx_ff <= 4'd0;
         j_ff <= 4'd0;
         k_ff <= '0;
      end else begin
         if (cmd.go) begin
            active_ff <= 1'b1;
            op_ff <= cmd.op;
            neg_ff <= neg_in;
         end else if (done) begin
            active_ff <= 1'b0;
         end
         if (cmd.capture) begin
            idx_ff <= req_data.term_index;
            m_ff <= m_sat;
            n_ff <= n_sat;
            mag_ff <= req_data.term_mag;
            ang_ff <= req_data.term_angle;
            q_ff <= req_data.spatial_freq;
            th_ff <= req_data.freq_angle;
         end
         if (done) begin
            case (op_ff)
               ape_pkg::OP_L_ANG: begin
                  tang_ff <= 16'(20'(n_ff) * 20'(ang_ff));
               end
               ape_pkg::OP_TX: begin
                  x_ff <= prod[44:14];
               end
               ape_pkg::OP_TX2: begin
                  x2_ff <= prod[61:30];
                  t_ff <= 31'(ape_pkg::ONE_Q30);
                  hidx_ff <= 4'd0;
               end
               ape_pkg::OP_TH1: begin
                  pq_ff <= prod[61:30];
               end
               ape_pkg::OP_TH2: begin
                  qh_ff <= prod[71:40];
               end
               ape_pkg::OP_TH3: begin
                  if (hidx_ff == 4'(ape_pkg::SIN_STEPS - 1)) begin
                     ts_ff <= new_t;
                     t_ff <= 31'(ape_pkg::ONE_Q30);
                  end else begin
                     t_ff <= new_t;
                  end
                  hidx_ff <= hidx_ff + 4'd1;
               end
               ape_pkg::OP_TS: begin
                  sn_ff <= sn_in;
                  cs_ff <= cs_in;
               end
               ape_pkg::OP_L_CX: begin
                  if (we) begin
                     m_tab[wi] <= m_ff;
                     n_tab[wi] <= n_ff;
                     cx_tab[wi] <= (m_ff == 4'd0) ? mag_ff : cl30[47:0];
                  end
               end
               ape_pkg::OP_L_SY: begin
                  if (we) begin
                     sy_tab[wi] <= cl30[47:0];
                  end
               end
               ape_pkg::OP_P_U: begin
                  u_ff <= prod[63:0];
                  sum_ff <= 48'sd0;
                  sat_ff <= 1'b0;
                  k_ff <= '0;
               end
               ape_pkg::OP_PW_INIT: begin
                  pw_ff <= ape_pkg::ONE_Q52;
                  j_ff <= 4'd0;
                  tang_ff <= 16'(20'(m_tab[ki]) * 20'(th_ff));
               end
               ape_pkg::OP_PW: begin
                  pw_ff <= ovf52 ? '1 : res52;
                  sat_ff <= sat_ff | ovf52;
                  j_ff <= j_ff + 4'd1;
               end
               ape_pkg::OP_T_C: begin
                  a_ff <= cl30[47:0];
                  sat_ff <= sat_ff | cl30[48];
               end
               ape_pkg::OP_T_S: begin
                  b_ff <= cl30[47:0];
                  sat_ff <= sat_ff | cl30[48];
               end
               ape_pkg::OP_INNER: begin
                  inner_ff <= inner_sum[47:0];
                  sat_ff <= sat_ff | inner_sum[48];
               end
               ape_pkg::OP_TERM: begin
                  term_ff <= cl52[47:0];
                  sat_ff <= sat_ff | cl52[48];
               end
               ape_pkg::OP_ACC: begin
                  sum_ff <= acc_sum[47:0];
                  sat_ff <= sat_ff | acc_sum[48];
                  k_ff <= k_ff + ape_pkg::K_W'(1);
               end
               default: begin
                  sat_ff <= sat_ff;
               end
            endcase
         end
      end
   end

   assign status.busy = active_ff;
   assign status.done = done;
   assign status.h_last = (hidx_ff == 4'(ape_pkg::TRIG_STEPS - 1));
   assign status.pw_more = (j_ff < n_tab[ki]);
   assign status.k_more = (k_ff < cnt);
   assign phase_shift = sum_ff;
   assign saturated = sat_ff;

endmodule

// File: design/ape_control.sv
// ---------------------------------------------------------------------------
// ape_control: sequencing state machine of the aberration phase evaluator
// Issues one datapath operation at a time and waits for its completion.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ape_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_action,
   input  logic               out_free,
   input  ape_pkg::stat_type  status,
   output logic               in_ready,
   output ape_pkg::cmd_type   cmd
);

   ape_pkg::state_type state_ff, state_in, succ;
   logic               wait_ff, wait_in;
   logic               pixel_ff, pixel_in;
   logic               has_op;
   ape_pkg::op_type    op_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ape_pkg::ST_IDLE;
         wait_ff <= 1'b0;
         pixel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         pixel_ff <= pixel_in;
      end
   end

   always_comb begin
      has_op = 1'b1;
      op_sel = ape_pkg::OP_NONE;
      succ = state_ff;
      case (state_ff)
         ape_pkg::ST_L_ANG: begin
            op_sel = ape_pkg::OP_L_ANG;
            succ = ape_pkg::ST_TX;
         end
         ape_pkg::ST_TX: begin
            op_sel = ape_pkg::OP_TX;
            succ = ape_pkg::ST_TX2;
         end
         ape_pkg::ST_TX2: begin
            op_sel = ape_pkg::OP_TX2;
            succ = ape_pkg::ST_TH1;
         end
         ape_pkg::ST_TH1: begin
            op_sel = ape_pkg::OP_TH1;
            succ = ape_pkg::ST_TH2;
         end
         ape_pkg::ST_TH2: begin
            op_sel = ape_pkg::OP_TH2;
            succ = ape_pkg::ST_TH3;
         end
         ape_pkg::ST_TH3: begin
            op_sel = ape_pkg::OP_TH3;
            succ = status.h_last ? ape_pkg::ST_TS : ape_pkg::ST_TH1;
         end
         ape_pkg::ST_TS: begin
            op_sel = ape_pkg::OP_TS;
            succ = pixel_ff ? ape_pkg::ST_T_C : ape_pkg::ST_L_CX;
         end
         ape_pkg::ST_L_CX: begin
            op_sel = ape_pkg::OP_L_CX;
            succ = ape_pkg::ST_L_SY;
         end
         ape_pkg::ST_L_SY: begin
            op_sel = ape_pkg::OP_L_SY;
            succ = ape_pkg::ST_IDLE;
         end
         ape_pkg::ST_P_U: begin
            op_sel = ape_pkg::OP_P_U;
            succ = ape_pkg::ST_K_CHK;
         end
         ape_pkg::ST_PW_INIT: begin
            op_sel = ape_pkg::OP_PW_INIT;
            succ = ape_pkg::ST_PW;
         end
         ape_pkg::ST_PW: begin
            op_sel = ape_pkg::OP_PW;
            succ = ape_pkg::ST_PW;
         end
         ape_pkg::ST_T_C: begin
            op_sel = ape_pkg::OP_T_C;
            succ = ape_pkg::ST_T_S;
         end
         ape_pkg::ST_T_S: begin
            op_sel = ape_pkg::OP_T_S;
            succ = ape_pkg::ST_INNER;
         end
         ape_pkg::ST_INNER: begin
            op_sel = ape_pkg::OP_INNER;
            succ = ape_pkg::ST_TERM;
         end
         ape_pkg::ST_TERM: begin
            op_sel = ape_pkg::OP_TERM;
            succ = ape_pkg::ST_ACC;
         end
         ape_pkg::ST_ACC: begin
            op_sel = ape_pkg::OP_ACC;
            succ = ape_pkg::ST_K_CHK;
         end
         default: begin
            has_op = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      pixel_in = pixel_ff;
      in_ready = 1'b0;
      cmd.go = 1'b0;
      cmd.op = op_sel;
      cmd.capture = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ape_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               pixel_in = in_action;
               state_in = in_action ? ape_pkg::ST_P_U : ape_pkg::ST_L_ANG;
            end
         end
         ape_pkg::ST_K_CHK: begin
            state_in = status.k_more ? ape_pkg::ST_PW_INIT : ape_pkg::ST_DONE;
         end
         ape_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ape_pkg::ST_IDLE;
            end
         end
         default: begin
            if (state_ff == ape_pkg::ST_PW && !wait_ff && !status.pw_more) begin
               // All radial factors are in; go on to the azimuthal trig.
               state_in = ape_pkg::ST_TX;
            end else if (has_op && !wait_ff) begin
               cmd.go = 1'b1;
               wait_in = 1'b1;
            end else if (has_op && status.done) begin
               wait_in = 1'b0;
               state_in = succ;
            end
         end
      endcase
   end

   // An operation is never issued on top of one still running.
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> !status.busy)
      else $error("operation issued while datapath busy");

   // The datapath takes up every issued operation.
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.go |=> status.busy)
      else $error("issued operation not started");

   // A captured item always leaves the idle state.
   a_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff != ape_pkg::ST_IDLE))
      else $error("captured item not processed");

   // A completion is seen only while waiting on an operation.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      status.done |-> wait_ff)
      else $error("completion without pending operation");

endmodule

// File: design/aberration_phase_evaluator_unit.sv
// ---------------------------------------------------------------------------
// aberration_phase_evaluator_unit: lens aberration phase (chi) evaluator
// A load item runs one sine/cosine series; a pixel item runs, for each summed
// term, a chain of n radial power products, n the term's radial power, and
// one series. All 64 x 64 products run on one shared multiplier.
// One item is in work at a time.
// Synchronous reset clears the control state and both registers; the term
// table is undefined until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aberration_phase_evaluator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ape_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ape_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // Configuration registers. The user must write them only while the block is
   // idle, which the block does not enforce; the datapath reads them directly.
   logic [31:0] wave_ff, wave_in;
   logic [4:0]  count_ff, count_in;
   logic        csr_write;

   // Output register: a finished item waits here while the next is taken.
   logic              rsp_valid_ff, rsp_valid_in;
   ape_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   ape_pkg::cmd_type  cmd;
   ape_pkg::stat_type status;
   logic signed [47:0] dp_phase;
   logic               dp_sat;
   logic               out_free;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      wave_in = wave_ff;
      count_in = count_ff;
      if (csr_write) begin
         case (paddr[2])
            ape_pkg::REG_WAVELENGTH: wave_in = pwdata;
            ape_pkg::REG_TERM_COUNT: count_in = pwdata[4:0];
            default: wave_in = wave_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         ape_pkg::REG_WAVELENGTH: prdata = wave_ff;
         ape_pkg::REG_TERM_COUNT: prdata = {27'd0, count_ff};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= 32'd0;
         count_ff <= 5'd0;
      end else begin
         wave_ff <= wave_in;
         count_ff <= count_in;
      end
   end

   // The result register may be refilled in the cycle its item is taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.phase_shift = dp_phase;
         rsp_data_in.saturated = dp_sat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The controller sequences one operation at a time through the datapath.
   ape_control u_control (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_action (req_data.action),
      .out_free  (out_free),
      .status    (status),
      .in_ready  (req_ready),
      .cmd       (cmd)
   );

   // The datapath holds the term table, the trig series registers and the sum.
   ape_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .wavelength  (wave_ff),
      .term_count  (count_ff),
      .status      (status),
      .phase_shift (dp_phase),
      .saturated   (dp_sat)
   );

endmodule

// File: tb/ape_checker.sv
// ---------------------------------------------------------------------------
// ape_checker: scoreboard for the aberration phase evaluator
// Watches the item channels and the register port, keeps its own copy of
// the term table and registers, predicts each pixel's phase and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ape_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ape_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ape_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               fail_count,
   output int               pending
);

   localparam longint POS_LIM = (longint'(1) << 47) - 1;
   localparam longint NEG_LIM = -(longint'(1) << 47);
   localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
   localparam logic [63:0] UNIT_Q52 = 64'd1 << 52;
   localparam logic [63:0] QUARTER_RAD = 64'd1686629713;
   localparam int SIN_DIVS [6] = '{156, 110, 72, 42, 20, 6};
   localparam int COS_DIVS [7] = '{182, 132, 90, 56, 30, 12, 2};

   logic [31:0] wave_reg;
   logic [4:0]  count_reg;
   logic [3:0]  m_slot [ape_pkg::MAX_TERMS];
   logic [3:0]  n_slot [ape_pkg::MAX_TERMS];
   longint      cx_slot [ape_pkg::MAX_TERMS];
   longint      sy_slot [ape_pkg::MAX_TERMS];
   ape_pkg::rsp_type phase_queue [$];
   int          results_seen;

   assign pending = phase_queue.size();

   // Rounded (a*b) >> sh, flagging anything past 64 bits.
   function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                             input int sh, inout logic ovf);
      logic [128:0] p;
      p = {65'd0, a} * {65'd0, b};
      p = p + (129'd1 << (sh - 1));
      p = p >> sh;
      if (p[128:64] != 0) begin
         ovf = 1'b1;
         return '1;
      end
      return p[63:0];
   endfunction

   function automatic longint clip_mag(input logic [63:0] r, input logic neg,
                                       input logic ovf, inout logic sat);
      logic [63:0] lim;
      lim = neg ? (64'd1 << 47) : 64'(POS_LIM);
      if (ovf || r > lim) begin
         r = lim;
         sat = 1'b1;
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint scale(input longint a, input logic [63:0] bmag,
                                    input logic bneg, input int sh, inout logic sat);
      logic        ovf;
      logic [63:0] amag;
      logic [63:0] r;
      ovf = 1'b0;
      amag = (a < 0) ? 64'(-a) : 64'(a);
      r = mul_round(amag, bmag, sh, ovf);
      return clip_mag(r, (a < 0) != bneg, ovf, sat);
   endfunction

   function automatic longint mul_trig(input longint a, input longint t, inout logic sat);
      return scale(a, (t < 0) ? 64'(-t) : 64'(t), t < 0, 30, sat);
   endfunction

   function automatic longint sat_add(input longint a, input longint b, inout logic sat);
      longint s;
      s = a + b;
      if (s > POS_LIM) begin
         s = POS_LIM;
         sat = 1'b1;
      end
      if (s < NEG_LIM) begin
         s = NEG_LIM;
         sat = 1'b1;
      end
      return s;
   endfunction

   function automatic logic [63:0] series_step(input logic [63:0] x2, input logic [63:0] t,
                                               input int k);
      logic [63:0] sub;
      sub = ((x2 * t) >> 30) / 64'(k);
      return (sub > UNIT_Q30) ? 64'd0 : UNIT_Q30 - sub;
   endfunction

   // Sine and cosine of a turn fraction, Q2.30.
   function automatic void turn_sincos(input logic [15:0] ang, output longint sn,
                                       output longint cs);
      logic [63:0] x, x2, ts, tc;
      longint      s, c;
      x = (64'(ang[13:0]) * QUARTER_RAD) >> 14;
      x2 = (x * x) >> 30;
      ts = UNIT_Q30;
      tc = UNIT_Q30;
      foreach (SIN_DIVS[i]) ts = series_step(x2, ts, SIN_DIVS[i]);
      foreach (COS_DIVS[i]) tc = series_step(x2, tc, COS_DIVS[i]);
      s = longint'((x * ts) >> 30);
      c = longint'(tc);
      case (ang[15:14])
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   task automatic store_term(input ape_pkg::req_type d);
      logic [3:0] m, n;
      logic [15:0] ang;
      longint mag, s, c;
      logic dropped;
      dropped = 1'b0;
      m = (d.term_m > ape_pkg::MAX_ORDER) ? 4'(ape_pkg::MAX_ORDER) : d.term_m;
      n = (d.term_n > ape_pkg::MAX_ORDER) ? 4'(ape_pkg::MAX_ORDER) : d.term_n;
      mag = {{16{d.term_mag[47]}}, d.term_mag};
      ang = 16'(n * d.term_angle);
      turn_sincos(ang, s, c);
      m_slot[d.term_index] = m;
      n_slot[d.term_index] = n;
      // Clipping while forming the coefficients is not reported.
      cx_slot[d.term_index] = (m == 0) ? mag : mul_trig(mag, c, dropped);
      sy_slot[d.term_index] = mul_trig(mag, s, dropped);
   endtask

   function automatic ape_pkg::rsp_type pixel_phase(input ape_pkg::req_type d);
      logic [63:0] u, pw;
      logic        sat, povf;
      longint      sum, s, c, inner, term, pc, ps;
      int          cnt;
      ape_pkg::rsp_type r;
      sat = 1'b0;
      sum = 0;
      u = 64'(wave_reg) * 64'(d.spatial_freq);
      cnt = (count_reg > ape_pkg::MAX_TERMS) ? ape_pkg::MAX_TERMS : int'(count_reg);
      for (int k = 0; k < cnt; k++) begin
         pw = UNIT_Q52;
         povf = 1'b0;
         for (int j = 0; j < n_slot[k]; j++) pw = mul_round(pw, u, 52, povf);
         if (povf) sat = 1'b1;
         turn_sincos(16'(m_slot[k] * d.freq_angle), s, c);
         pc = mul_trig(cx_slot[k], c, sat);
         ps = mul_trig(sy_slot[k], s, sat);
         inner = sat_add(pc, ps, sat);
         term = scale(inner, pw, 1'b0, 52, sat);
         sum = sat_add(sum, term, sat);
      end
      r.phase_shift = sum[47:0];
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: result %0d %s", $time, results_seen, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      results_seen = 0;
      foreach (m_slot[i]) begin
         m_slot[i] = '0;
         n_slot[i] = '0;
         cx_slot[i] = 0;
         sy_slot[i] = 0;
      end
   end

   always @(posedge clock) begin
      ape_pkg::rsp_type want;
      if (reset) begin
         wave_reg <= '0;
         count_reg <= '0;
         phase_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ape_pkg::REG_WAVELENGTH) wave_reg <= pwdata;
            else count_reg <= pwdata[4:0];
         end
         if (req_valid && req_ready) begin
            if (req_data.action)
               phase_queue.insert(phase_queue.size(), pixel_phase(req_data));
            else store_term(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (phase_queue.size() == 0) begin
               report_mismatch("arrived with no pixel pending");
            end else begin
               want = phase_queue.pop_front();
               if (rsp_data.phase_shift !== want.phase_shift)
                  report_mismatch($sformatf("phase_shift mismatch: expected %h, got %h",
                                            want.phase_shift, rsp_data.phase_shift));
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch($sformatf("saturated mismatch: expected %b, got %b",
                                            want.saturated, rsp_data.saturated));
            end
            results_seen++;
         end
      end
   end

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: top of the aberration phase evaluator testbench
// Drives term loads and pixel items with random idling on both sides,
// reprograms wavelength and term count between phases, and reports the
// verdict that the scoreboard module arrives at.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // A load can still be in flight after the last pixel result, so the
   // block is given this many cycles before any register write.
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES = 3000;
   localparam int ITEMS_PER_PHASE = 370;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ape_pkg::req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   ape_pkg::rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;

   // Idling percentages of the current phase and the long receiver hold-off.
   int          send_idle_pct;
   int          recv_stall_pct;
   logic        hold_request;
   int          loads_sent;
   int          pixels_sent;
   int          settings_used;

   aberration_phase_evaluator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ape_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is bounded by a fixed time far above the slowest correct run.
   initial begin
      #100_000_000;
      $display("Timeout with %0d pixel results outstanding.", pending);
      $display("== FAIL ==");
      $finish;
   end

   // The receiver stalls at random at the phase's rate. When a hold-off is
   // requested it refuses results for a long stretch, so that the block
   // fills up and backs up onto its input channel.
   initial begin
      int held;
      held = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && held < HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
            held++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // One item on the request channel. Random idle cycles come first; the
   // valid is then held with its payload until the block takes the item.
   // Ready is looked at on the falling edge, where it is stable.
   task automatic send_item(input ape_pkg::req_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (d.action) pixels_sent++;
      else loads_sent++;
   endtask

   // A register write: a setup phase, then an access phase, then the port
   // returns to idle.
   task automatic write_reg(input logic index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Drops valid, waits for every pixel result, then lets any load finish.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] wave, input logic [4:0] terms);
      drain();
      write_reg(ape_pkg::REG_WAVELENGTH, wave);
      write_reg(ape_pkg::REG_TERM_COUNT, 32'(terms));
      settings_used++;
   endtask

   function automatic ape_pkg::req_type random_fields();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(ape_pkg::req_type)-1:0];
   endfunction

   function automatic ape_pkg::req_type random_load();
      ape_pkg::req_type d;
      d = random_fields();
      d.action = 1'b0;
      // Most magnitudes are moderate so that products stay in range.
      if ($urandom_range(3) != 0) d.term_mag = 48'(signed'(20'($urandom)));
      return d;
   endfunction

   function automatic ape_pkg::req_type random_pixel();
      ape_pkg::req_type d;
      d = random_fields();
      d.action = 1'b1;
      case ($urandom_range(3))
         0: d.spatial_freq = $urandom;
         1: d.spatial_freq = '1;
         default: d.spatial_freq = $urandom_range(32'h0400_0000);
      endcase
      return d;
   endfunction

   initial begin
      ape_pkg::req_type d;
      logic [31:0] waves [4];
      logic [4:0]  counts [4];
      int          stall_modes [4][2];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      loads_sent = 0;
      pixels_sent = 0;
      settings_used = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Every slot is loaded first, so no pixel ever sums a
      // slot that was never written. Orders above the maximum, magnitude
      // extremes and the quadrant boundaries of the angle all appear.
      for (int i = 0; i < ape_pkg::MAX_TERMS; i++) begin
         d = random_load();
         d.term_index = 4'(i);
         d.term_m = 4'(i);
         d.term_n = 4'(15 - i);
         case (i)
            0: d.term_mag = 48'h7FFF_FFFF_FFFF;
            1: d.term_mag = 48'h8000_0000_0000;
            2: d.term_mag = '0;
            3: d.term_mag = '1;
            default: ;
         endcase
         case (i % 6)
            0: d.term_angle = 16'h0000;
            1: d.term_angle = 16'hFFFF;
            2: d.term_angle = 16'h4000;
            3: d.term_angle = 16'h8000;
            4: d.term_angle = 16'hC000;
            default: ;
         endcase
         send_item(d);
      end
      // An empty term count gives a zero phase.
      configure(32'h1000_0000, 5'd0);
      send_item(random_pixel());
      // The whole table at the largest wavelength, which saturates.
      configure(32'hFFFF_FFFF, 5'(ape_pkg::MAX_TERMS));
      d = random_pixel();
      d.spatial_freq = '1;
      d.freq_angle = 16'hFFFF;
      send_item(d);
      d.spatial_freq = '0;
      d.freq_angle = 16'h0000;
      send_item(d);
      d.spatial_freq = 32'h0100_0000;
      d.freq_angle = 16'h4000;
      send_item(d);
      configure(32'h1000_0000, 5'd3);
      d.spatial_freq = 32'h0080_0000;
      d.freq_angle = 16'h8000;
      send_item(d);

      // Random part: four phases with different idling and settings. Term
      // counts stay small so that pixels stay short.
      waves = '{32'hFFFF_FFFF, 32'h0, 32'h0040_0000, 32'h0};
      waves[1] = $urandom;
      waves[3] = 32'h0;
      counts = '{5'd1, 5'd2, 5'd3, 5'd5};
      stall_modes = '{'{0, 0}, '{88, 0}, '{0, 88}, '{27, 27}};
      for (int p = 0; p < 4; p++) begin
         configure(waves[p], counts[p]);
         send_idle_pct = stall_modes[p][0];
         recv_stall_pct = stall_modes[p][1];
         // The long hold-off comes while items are offered back to back.
         if (p == 0) hold_request = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(99) < 40) send_item(random_load());
            else send_item(random_pixel());
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();

      $display("Covered %0d term loads and %0d pixel items over %0d register settings,",
               loads_sent, pixels_sent, settings_used);
      $display("with idle senders, stalled receivers and one long receiver hold-off.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/ape_pkg.sv
design/ape_mul64.sv
design/ape_datapath.sv
design/ape_control.sv
design/aberration_phase_evaluator_unit.sv
tb/ape_checker.sv
tb/tb.sv
